// File: hw/rtl/lzt_pkg.sv
// Shared constants, command codes and status type for the LZ77 tokenizer.
package lzt_pkg;

   localparam int BUFFER_BYTES_DEF  = 65536;
   localparam int WINDOW_BYTES_DEF  = 4096;
   localparam int HASH_ENTRIES_DEF  = 4096;
   localparam int LONGEST_MATCH_DEF = 255;

   localparam int MIN_MATCH     = 3;
   localparam int CHAIN_DEFAULT = 64;
   localparam int OFFSET_W      = 13;
   localparam int LENGTH_W      = 8;
   localparam int LIMIT_W       = 7;
   localparam int HSUM_W        = 17;
   localparam int HSTEP_W       = 5;
   localparam int HSTEP_TOP     = 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   localparam logic REG_SEARCH_MODE = 1'b0;
   localparam logic REG_CHAIN_LIMIT = 1'b1;

   localparam logic STATUS_TOKEN = 1'b0;
   localparam logic STATUS_NONE  = 1'b1;

   typedef logic [4:0] op_type;
   localparam op_type OP_IDLE        = 5'd0;
   localparam op_type OP_LOAD        = 5'd1;
   localparam op_type OP_CLR         = 5'd2;
   localparam op_type OP_START       = 5'd3;
   localparam op_type OP_HRD0        = 5'd4;
   localparam op_type OP_HRD1        = 5'd5;
   localparam op_type OP_HSUM        = 5'd6;
   localparam op_type OP_HMOD        = 5'd7;
   localparam op_type OP_HEAD_RD     = 5'd8;
   localparam op_type OP_INS         = 5'd9;
   localparam op_type OP_FIND_INIT   = 5'd10;
   localparam op_type OP_LINK_HEAD   = 5'd11;
   localparam op_type OP_CMP_INIT_EX = 5'd12;
   localparam op_type OP_CMP_INIT_CH = 5'd13;
   localparam op_type OP_CMP_RD      = 5'd14;
   localparam op_type OP_CMP_EQ      = 5'd15;
   localparam op_type OP_CMP_DONE    = 5'd16;
   localparam op_type OP_LINK_RD     = 5'd17;
   localparam op_type OP_LINK_TAKE   = 5'd18;
   localparam op_type OP_FIN         = 5'd19;
   localparam op_type OP_EMIT        = 5'd20;
   localparam op_type OP_EMIT_NONE   = 5'd21;

   typedef struct packed {
      logic tok_ok;
      logic new_input;
      logic do_ins;
      logic do_find;
      logic chain_start;
      logic ex_more;
      logic chain_ok;
      logic n_lt_lim;
      logic eq;
      logic k_zero;
      logic hit_max;
      logic clr_last;
   } dp_status_type;

endpackage

// File: hw/rtl/lzt_datapath.sv
// Datapath: byte buffer, hash heads, chain links, hash unit and match compare.
module lzt_datapath #(
   parameter int BUFFER_BYTES  = lzt_pkg::BUFFER_BYTES_DEF,
   parameter int WINDOW_BYTES  = lzt_pkg::WINDOW_BYTES_DEF,
   parameter int HASH_ENTRIES  = lzt_pkg::HASH_ENTRIES_DEF,
   parameter int LONGEST_MATCH = lzt_pkg::LONGEST_MATCH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lzt_pkg::op_type                 op,
   input  logic                            search_mode,
   input  logic [lzt_pkg::LIMIT_W-1:0]     chain_limit,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output lzt_pkg::dp_status_type          status,
   output logic                            rsp_strobe,
   output logic                            rsp_status,
   output logic [lzt_pkg::OFFSET_W-1:0]    rsp_offset,
   output logic [lzt_pkg::LENGTH_W-1:0]    rsp_length,
   output logic [7:0]                      rsp_next_char,
   output logic                            rsp_last_token,
   output logic                            rsp_truncated
);
   import lzt_pkg::*;

   localparam int PW  = $clog2(BUFFER_BYTES + 1);
   localparam int AW  = $clog2(BUFFER_BYTES);
   localparam int HW  = $clog2(HASH_ENTRIES);
   localparam int WW  = 34;
   localparam logic [HSUM_W-1:0] HRECIP = HSUM_W'((64'd1 << HSUM_W) / 64'(HASH_ENTRIES));

   // memories
   logic [7:0]    buf_mem  [BUFFER_BYTES];
   logic [PW-1:0] head_mem [HASH_ENTRIES];
   logic [PW-1:0] link_mem [BUFFER_BYTES];

   logic [PW-1:0] len_ff, rp_ff, pos_ff, hp_ff, cand_ff, link_ff, bo_ff;
   logic          complete_ff, ovf_ff;
   logic [7:0]    b0_ff, b1_ff, rda_ff, rdb_ff;
   logic [HSUM_W-1:0] rem_ff, hq_ff;
   logic [HSTEP_W-1:0] k_ff;
   logic [LENGTH_W-1:0] n_ff, lim_ff, bl_ff;
   logic [LIMIT_W-1:0]  scanned_ff;
   logic [HW-1:0] clr_ff;
   logic [PW-1:0] head_q_ff, link_q_ff;

   logic [PW-1:0] ws, lm1, cand_nx, rem_len, off_nx, next_rp;
   logic [LENGTH_W-1:0] lim_c, blf;
   logic [PW-1:0] bof;
   logic [HSUM_W-1:0] hsum;
   logic [WW-1:0] hprod;
   logic [HSUM_W-1:0] hquo;
   logic [WW-1:0] hmul;
   logic          hsub;
   logic [HW-1:0] hash_idx;
   logic [AW-1:0] addr_a, addr_b;
   logic          buf_we;
   logic [AW-1:0] buf_waddr;

   // window start and candidate limits
   always_comb begin
      if (32'(pos_ff) > 32'(WINDOW_BYTES)) begin
         ws = PW'(32'(pos_ff) - 32'(WINDOW_BYTES));
      end else begin
         ws = '0;
      end
      lm1     = link_ff - PW'(1);
      cand_nx = (op == OP_CMP_INIT_CH) ? lm1 : cand_ff;
      rem_len = len_ff - pos_ff - PW'(1);
      off_nx  = pos_ff - cand_nx;
      lim_c   = LENGTH_W'(LONGEST_MATCH);
      if (32'(rem_len) < 32'(lim_c)) begin
         lim_c = LENGTH_W'(rem_len);
      end
      if (32'(off_nx) < 32'(lim_c)) begin
         lim_c = LENGTH_W'(off_nx);
      end
      if (32'(bl_ff) < MIN_MATCH) begin
         blf = '0;
         bof = '0;
      end else begin
         blf = bl_ff;
         bof = bo_ff;
      end
      next_rp = pos_ff + PW'(bl_ff) + PW'(1);
   end

   // hash: sum of weighted bytes, remainder by reciprocal estimate and one correction
   always_comb begin
      hsum = HSUM_W'({b0_ff, 8'b0}) + HSUM_W'(b0_ff) + HSUM_W'({b1_ff, 4'b0})
           + HSUM_W'(b1_ff) + HSUM_W'(rda_ff);
      hprod = WW'(rem_ff) * WW'(HRECIP);
      hquo  = HSUM_W'(hprod >> HSUM_W);
      hmul  = WW'(hq_ff) * WW'(HASH_ENTRIES);
      hsub  = WW'(rem_ff) >= WW'(HASH_ENTRIES);
      hash_idx = HW'(rem_ff);
   end

   // buffer read addresses
   always_comb begin
      addr_a = '0;
      addr_b = '0;
      case (op)
         OP_HRD0: begin
            addr_a = AW'(hp_ff);
            addr_b = AW'(hp_ff + PW'(1));
         end
         OP_HRD1: addr_a = AW'(hp_ff + PW'(2));
         OP_CMP_RD: begin
            addr_a = AW'(cand_ff + PW'(n_ff));
            addr_b = AW'(pos_ff + PW'(n_ff));
         end
         OP_FIN: addr_a = AW'(pos_ff + PW'(blf));
         default: addr_a = '0;
      endcase
      buf_we    = (op == OP_LOAD) && (complete_ff || (32'(len_ff) < BUFFER_BYTES));
      buf_waddr = complete_ff ? '0 : AW'(len_ff);
   end

   // byte buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= req_data_byte;
      end
      rda_ff <= buf_mem[addr_a];
      rdb_ff <= buf_mem[addr_b];
   end

   // hash heads: clear sweep, insert, read
   always_ff @(posedge clock) begin
      if (op == OP_CLR) begin
         head_mem[clr_ff] <= '0;
      end else if (op == OP_INS) begin
         head_mem[hash_idx] <= hp_ff + PW'(1);
      end
      if (op == OP_HEAD_RD) begin
         head_q_ff <= head_mem[hash_idx];
      end
   end

   // chain links
   always_ff @(posedge clock) begin
      if (op == OP_INS) begin
         link_mem[AW'(hp_ff)] <= head_q_ff;
      end
      if (op == OP_LINK_RD) begin
         link_q_ff <= link_mem[AW'(cand_ff)];
      end
   end

   // control registers of the input and clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         rp_ff       <= '0;
         complete_ff <= 1'b0;
         ovf_ff      <= 1'b0;
         clr_ff      <= '0;
      end else begin
         case (op)
            OP_LOAD: begin
               if (complete_ff) begin
                  len_ff <= PW'(1);
                  rp_ff  <= '0;
                  ovf_ff <= 1'b0;
                  clr_ff <= '0;
               end else if (32'(len_ff) < BUFFER_BYTES) begin
                  len_ff <= len_ff + PW'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               complete_ff <= req_last_byte;
            end
            OP_CLR:  clr_ff <= clr_ff + HW'(1);
            OP_EMIT: rp_ff  <= next_rp;
            default: rp_ff  <= rp_ff;
         endcase
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      case (op)
         OP_START: begin
            pos_ff <= rp_ff;
            hp_ff  <= rp_ff - PW'(1);
            bl_ff  <= '0;
            bo_ff  <= '0;
         end
         OP_HRD1: begin
            b0_ff <= rda_ff;
            b1_ff <= rdb_ff;
         end
         OP_HSUM: begin
            rem_ff <= hsum;
            k_ff   <= HSTEP_W'(HSTEP_TOP);
         end
         OP_HMOD: begin
            // estimate the quotient, take it off, then correct by one step
            if (k_ff == HSTEP_W'(HSTEP_TOP)) begin
               hq_ff <= hquo;
            end else if (k_ff != '0) begin
               rem_ff <= HSUM_W'(WW'(rem_ff) - hmul);
            end else if (hsub) begin
               rem_ff <= HSUM_W'(WW'(rem_ff) - WW'(HASH_ENTRIES));
            end
            k_ff <= k_ff - HSTEP_W'(1);
         end
         OP_FIND_INIT: begin
            hp_ff      <= pos_ff;
            cand_ff    <= ws;
            scanned_ff <= '0;
         end
         OP_LINK_HEAD: link_ff <= head_q_ff;
         OP_CMP_INIT_EX, OP_CMP_INIT_CH: begin
            cand_ff <= cand_nx;
            n_ff    <= '0;
            lim_ff  <= lim_c;
         end
         OP_CMP_EQ: begin
            if (rda_ff == rdb_ff) begin
               n_ff <= n_ff + LENGTH_W'(1);
            end
         end
         OP_CMP_DONE: begin
            if (n_ff > bl_ff) begin
               bl_ff <= n_ff;
               bo_ff <= pos_ff - cand_ff;
            end
            if (search_mode) begin
               cand_ff <= cand_ff + PW'(1);
            end
         end
         OP_LINK_TAKE: begin
            link_ff    <= link_q_ff;
            scanned_ff <= scanned_ff + LIMIT_W'(1);
         end
         OP_FIN: begin
            bl_ff <= blf;
            bo_ff <= bof;
         end
         default: hp_ff <= hp_ff;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (op == OP_EMIT) || (op == OP_EMIT_NONE);
      end
      rsp_truncated <= ovf_ff;
      if (op == OP_EMIT) begin
         rsp_status     <= STATUS_TOKEN;
         rsp_offset     <= OFFSET_W'(bo_ff);
         rsp_length     <= bl_ff;
         rsp_next_char  <= rda_ff;
         rsp_last_token <= next_rp >= len_ff;
      end else begin
         rsp_status     <= STATUS_NONE;
         rsp_offset     <= '0;
         rsp_length     <= '0;
         rsp_next_char  <= '0;
         rsp_last_token <= 1'b0;
      end
   end

   // status to the controller
   always_comb begin
      status.tok_ok      = complete_ff && (rp_ff < len_ff);
      status.new_input   = complete_ff;
      status.do_ins      = (pos_ff != '0) && ((pos_ff + PW'(1)) < len_ff);
      status.do_find     = (pos_ff + PW'(1)) < len_ff;
      status.chain_start = ({1'b0, pos_ff} + (PW + 1)'(3)) < {1'b0, len_ff};
      status.ex_more     = cand_ff < pos_ff;
      status.chain_ok    = (link_ff != '0) && (scanned_ff < chain_limit)
                           && (lm1 >= ws) && (lm1 < pos_ff);
      status.n_lt_lim    = n_ff < lim_ff;
      status.eq          = rda_ff == rdb_ff;
      status.k_zero      = k_ff == '0;
      status.hit_max     = (n_ff > bl_ff) && (32'(n_ff) == LONGEST_MATCH);
      status.clr_last    = 32'(clr_ff) == (HASH_ENTRIES - 1);
   end

endmodule

// File: hw/rtl/lzt_ctrl.sv
// Controller: sequences loads, head clearing, insertion, search and emit.
module lzt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_kind,
   input  logic                   search_mode,
   input  lzt_pkg::dp_status_type status,
   output lzt_pkg::op_type        op,
   output logic                   busy
);
   import lzt_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CLR      = 5'd1;
   localparam logic [4:0] S_NONE     = 5'd2;
   localparam logic [4:0] S_INS_CHK  = 5'd3;
   localparam logic [4:0] S_H0       = 5'd4;
   localparam logic [4:0] S_H1       = 5'd5;
   localparam logic [4:0] S_HSUM     = 5'd6;
   localparam logic [4:0] S_HMOD     = 5'd7;
   localparam logic [4:0] S_HEAD_RD  = 5'd8;
   localparam logic [4:0] S_HEADQ    = 5'd9;
   localparam logic [4:0] S_FIND_CHK = 5'd10;
   localparam logic [4:0] S_EX_CHK   = 5'd11;
   localparam logic [4:0] S_CH_CHK   = 5'd12;
   localparam logic [4:0] S_CMP      = 5'd13;
   localparam logic [4:0] S_CMPEQ    = 5'd14;
   localparam logic [4:0] S_CMP_DONE = 5'd15;
   localparam logic [4:0] S_LINK_RD  = 5'd16;
   localparam logic [4:0] S_LINK_TK  = 5'd17;
   localparam logic [4:0] S_FIN      = 5'd18;
   localparam logic [4:0] S_EMIT     = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       find_ff, find_in;

   // next state and command
   always_comb begin
      state_in = state_ff;
      find_in  = find_ff;
      op       = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (start && req_kind == KIND_LOAD) begin
               op = OP_LOAD;
               if (status.new_input) begin
                  state_in = S_CLR;
               end
            end else if (start) begin
               if (status.tok_ok) begin
                  op       = OP_START;
                  find_in  = 1'b0;
                  state_in = S_INS_CHK;
               end else begin
                  state_in = S_NONE;
               end
            end
         end
         S_CLR: begin
            op = OP_CLR;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_NONE: begin
            op       = OP_EMIT_NONE;
            state_in = S_IDLE;
         end
         S_INS_CHK: state_in = status.do_ins ? S_H0 : S_FIND_CHK;
         S_H0: begin
            op       = OP_HRD0;
            state_in = S_H1;
         end
         S_H1: begin
            op       = OP_HRD1;
            state_in = S_HSUM;
         end
         S_HSUM: begin
            op       = OP_HSUM;
            state_in = S_HMOD;
         end
         S_HMOD: begin
            op = OP_HMOD;
            if (status.k_zero) begin
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            op       = OP_HEAD_RD;
            state_in = S_HEADQ;
         end
         S_HEADQ: begin
            if (find_ff) begin
               op       = OP_LINK_HEAD;
               state_in = S_CH_CHK;
            end else begin
               op       = OP_INS;
               state_in = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (!status.do_find) begin
               state_in = S_FIN;
            end else if (search_mode) begin
               op       = OP_FIND_INIT;
               state_in = S_EX_CHK;
            end else if (status.chain_start) begin
               op       = OP_FIND_INIT;
               find_in  = 1'b1;
               state_in = S_H0;
            end else begin
               state_in = S_FIN;
            end
         end
         S_EX_CHK: begin
            if (status.ex_more) begin
               op       = OP_CMP_INIT_EX;
               state_in = S_CMP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CH_CHK: begin
            if (status.chain_ok) begin
               op       = OP_CMP_INIT_CH;
               state_in = S_CMP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CMP: begin
            if (status.n_lt_lim) begin
               op       = OP_CMP_RD;
               state_in = S_CMPEQ;
            end else begin
               state_in = S_CMP_DONE;
            end
         end
         S_CMPEQ: begin
            op       = OP_CMP_EQ;
            state_in = status.eq ? S_CMP : S_CMP_DONE;
         end
         S_CMP_DONE: begin
            op = OP_CMP_DONE;
            if (search_mode) begin
               state_in = S_EX_CHK;
            end else if (status.hit_max) begin
               state_in = S_FIN;
            end else begin
               state_in = S_LINK_RD;
            end
         end
         S_LINK_RD: begin
            op       = OP_LINK_RD;
            state_in = S_LINK_TK;
         end
         S_LINK_TK: begin
            op       = OP_LINK_TAKE;
            state_in = S_CH_CHK;
         end
         S_FIN: begin
            op       = OP_FIN;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            op       = OP_EMIT;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state; reset starts with a head clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         find_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         find_ff  <= find_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// File: hw/rtl/lz77_hash_chain_tokenizer.sv
// Top level: LZ77 hash-chain tokenizer with its register port.
//
//   channel   ports                        handshake
//   request   req_kind/data_byte/last_byte start high while busy low
//   result    rsp_* fields                 rsp_strobe, one cycle, no stall
//   config    psel/penable/pwrite/paddr    APB write on access, pready high
//
// A load item is taken in the idle state. A load that begins a new input, and reset,
// run a clearing sweep over all HASH_ENTRIES hash heads.
// A pull item hashes the inserted position and, in chain mode, the searched one
// (read the bytes, sum them, reduce modulo HASH_ENTRIES), then compares each
// candidate byte by byte (read both bytes, then test them), walking the hash
// chain, or every window position in the exhaustive scan.
// Reset is synchronous; results appear on rsp_* for one cycle only.
module lz77_hash_chain_tokenizer #(
   parameter int BUFFER_BYTES  = lzt_pkg::BUFFER_BYTES_DEF,
   parameter int WINDOW_BYTES  = lzt_pkg::WINDOW_BYTES_DEF,
   parameter int HASH_ENTRIES  = lzt_pkg::HASH_ENTRIES_DEF,
   parameter int LONGEST_MATCH = lzt_pkg::LONGEST_MATCH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_strobe,
   output logic                         rsp_status,
   output logic [lzt_pkg::OFFSET_W-1:0] rsp_offset,
   output logic [lzt_pkg::LENGTH_W-1:0] rsp_length,
   output logic [7:0]                   rsp_next_char,
   output logic                         rsp_last_token,
   output logic                         rsp_truncated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import lzt_pkg::*;

   logic               mode_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               csr_wr;
   op_type             op;
   dp_status_type      status;

   // register writes
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         limit_ff <= LIMIT_W'(CHAIN_DEFAULT);
      end else if (csr_wr) begin
         if (paddr[2] == REG_SEARCH_MODE) begin
            mode_ff <= pwdata[0];
         end else begin
            limit_ff <= pwdata[LIMIT_W-1:0];
         end
      end
   end

   // register reads
   always_comb begin
      if (paddr[2] == REG_CHAIN_LIMIT) begin
         prdata = 32'(limit_ff);
      end else begin
         prdata = 32'(mode_ff);
      end
   end

   lzt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_kind    (req_kind),
      .search_mode (mode_ff),
      .status      (status),
      .op          (op),
      .busy        (busy)
   );

   lzt_datapath #(
      .BUFFER_BYTES  (BUFFER_BYTES),
      .WINDOW_BYTES  (WINDOW_BYTES),
      .HASH_ENTRIES  (HASH_ENTRIES),
      .LONGEST_MATCH (LONGEST_MATCH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .search_mode    (mode_ff),
      .chain_limit    (limit_ff),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_offset     (rsp_offset),
      .rsp_length     (rsp_length),
      .rsp_next_char  (rsp_next_char),
      .rsp_last_token (rsp_last_token),
      .rsp_truncated  (rsp_truncated)
   );

`ifndef SYNTHESIS
   a_pull_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_PULL) |=> busy)
      else $error("pull item did not start a search");
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without work");
   a_none_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_NONE) |-> (rsp_length == '0 && rsp_offset == '0))
      else $error("no-token result carries a match");
   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_TOKEN)
      |-> (rsp_length == '0 || 32'(rsp_length) >= MIN_MATCH))
      else $error("match shorter than minimum");
`endif

endmodule
